// ===== hw/rtl/cau_pkg.sv =====
// Shared widths, opcodes and the item record of the iterative pipeline section.
`default_nettype none
package cau_pkg;

	localparam int DW = 32;               // word width of every operand and result
	localparam int FB = 16;               // fraction bits
	localparam int PW = 2 * DW;           // product width
	localparam int WW = 2 * DW + 2;       // signed width of sums before clamping
	localparam int NW = 2 * DW + FB;      // dividend magnitude width
	localparam int QW = DW + 2;           // quotient bits, the top one marks overflow
	localparam int CW = PW + QW - 1;      // width of the shifted divisor compare
	localparam int RW = DW + 2;           // square root remainder width

	typedef enum logic [2:0] {
		OP_ADD  = 3'd0,
		OP_SUB  = 3'd1,
		OP_MUL  = 3'd2,
		OP_DIV  = 3'd3,
		OP_SDIV = 3'd4,
		OP_MOD  = 3'd5,
		OP_MOD2 = 3'd6,
		OP_CONJ = 3'd7
	} op_t;

	typedef struct packed {
		op_t                    op;
		logic                   zdiv;
		logic signed [WW-1:0]   fast_re;
		logic signed [WW-1:0]   fast_im;
		logic [PW-1:0]          den;
		logic [NW-1:0]          rem_re;
		logic [NW-1:0]          rem_im;
		logic                   neg_re;
		logic                   neg_im;
		logic [QW-1:0]          q_re;
		logic [QW-1:0]          q_im;
		logic [PW-1:0]          sq_s;
		logic [RW-1:0]          sq_rem;
		logic [DW-1:0]          sq_root;
	} iter_t;

endpackage
`default_nettype wire

// ===== hw/rtl/cau_iter_pipe.sv =====
// Pipelined restoring dividers (real and imaginary) and digit-by-digit square root.
`default_nettype none
module cau_iter_pipe (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire cau_pkg::iter_t in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output cau_pkg::iter_t      out_data
);
	import cau_pkg::*;

	iter_t       data_s [QW];
	logic [QW-1:0] vld_s;
	logic [QW:0]   rdy;

	assign rdy[QW]   = out_ready;
	assign in_ready  = rdy[0];
	assign out_valid = vld_s[QW-1];
	assign out_data  = data_s[QW-1];

	for (genvar j = 0; j < QW; j++) begin : g_step
		localparam int K = QW - 1 - j;
		iter_t           cur;
		iter_t           nxt;
		logic            cur_vld;
		logic [CW-1:0]   dsh;
		logic [CW-1:0]   rre;
		logic [CW-1:0]   rim;
		logic            ge_re;
		logic            ge_im;
		logic [RW-1:0]   sq_rem_n;
		logic [DW-1:0]   sq_root_n;

		if (j == 0) begin : g_first
			assign cur     = in_data;
			assign cur_vld = in_valid;
		end else begin : g_next
			assign cur     = data_s[j-1];
			assign cur_vld = vld_s[j-1];
		end

		// Square root digits only exist for the low DW quotient positions.
		if (K < DW) begin : g_sqrt
			logic [RW-1:0] rem2;
			logic [RW-1:0] trial;
			logic          ge_sq;
			always_comb begin
				rem2      = {cur.sq_rem[RW-3:0], cur.sq_s[2*K +: 2]};
				trial     = {cur.sq_root, 2'b01};
				ge_sq     = (rem2 >= trial);
				sq_rem_n  = ge_sq ? (rem2 - trial) : rem2;
				sq_root_n = {cur.sq_root[DW-2:0], ge_sq};
			end
		end else begin : g_nosqrt
			assign sq_rem_n  = cur.sq_rem;
			assign sq_root_n = cur.sq_root;
		end

		always_comb begin
			nxt   = cur;
			dsh   = CW'(cur.den) << K;
			rre   = CW'(cur.rem_re);
			rim   = CW'(cur.rem_im);
			ge_re = (rre >= dsh);
			ge_im = (rim >= dsh);
			if (ge_re) begin
				nxt.rem_re = NW'(rre - dsh);
			end
			if (ge_im) begin
				nxt.rem_im = NW'(rim - dsh);
			end
			nxt.q_re[K] = ge_re;
			nxt.q_im[K] = ge_im;
			nxt.sq_rem  = sq_rem_n;
			nxt.sq_root = sq_root_n;
		end

		assign rdy[j] = !vld_s[j] || rdy[j+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (rdy[j]) begin
				vld_s[j] <= cur_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[j] && cur_vld) begin
				data_s[j] <= nxt;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/complex_arithmetic_unit.sv =====
// Top level of the pipelined Q16.16 complex arithmetic unit.
`default_nettype none
// Channel   Direction  Ports                          Contents
// s_*       in         s_tvalid s_tready s_tdata      a_re, a_im, b_re, b_im (128 bits)
//                      s_tuser                        req_type (3 bits)
// m_*       out        m_tvalid m_tready m_tdata      res_re, res_im (64 bits)
//                      m_tuser                        zero_divisor, saturated (2 bits)
//
// One item may enter every cycle while m_tready does not stall the output; each item
// passes one multiply stage, one sum stage, one operand setup stage, 34 divider stages
// (one quotient bit per stage, and one square-root digit in each of the last 32)
// and the clamping output register. Every stage has its own valid bit and takes a
// new item whenever it is empty or its successor moves, so a stall on m_tready fills
// the bubbles first and nothing is dropped or repeated. Reset clears only valid bits.
module complex_arithmetic_unit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [127:0]  s_tdata,   // a_re, a_im, b_re, b_im from bit 0 up
	input  wire logic [2:0]    s_tuser,   // req_type
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [63:0]        m_tdata,   // res_re, res_im from bit 0 up
	output logic [1:0]         m_tuser    // zero_divisor, saturated from bit 0 up
);
	import cau_pkg::*;

	localparam logic signed [WW-1:0] MAXV = {{(WW-DW+1){1'b0}}, {(DW-1){1'b1}}};
	localparam logic signed [WW-1:0] MINV = {{(WW-DW+1){1'b1}}, {(DW-1){1'b0}}};

	// Clamp to the word range; the top bit of the result is the saturation flag.
	function automatic logic [DW:0] clamp_fn(input logic signed [WW-1:0] v);
		logic [DW:0] r;
		if (v > MAXV) begin
			r = {1'b1, MAXV[DW-1:0]};
		end else if (v < MINV) begin
			r = {1'b1, MINV[DW-1:0]};
		end else begin
			r = {1'b0, v[DW-1:0]};
		end
		return r;
	endfunction

	// Signed quotient from the magnitude; an overflowed top bit pushes past the range.
	function automatic logic signed [WW-1:0] quot_fn(input logic [QW-1:0] q, input logic neg);
		logic signed [WW-1:0] m;
		logic signed [WW-1:0] r;
		m = signed'({{(WW-QW){1'b0}}, q});
		if (q[QW-1]) begin
			r = neg ? (MINV - WW'(1)) : (MAXV + WW'(1));
		end else begin
			r = neg ? -m : m;
		end
		return r;
	endfunction

	// ---------------- input fields ----------------
	op_t                   op_in;
	logic signed [DW-1:0]  a_re;
	logic signed [DW-1:0]  a_im;
	logic signed [DW-1:0]  b_re;
	logic signed [DW-1:0]  b_im;
	logic signed [PW-1:0]  ar_w;
	logic signed [PW-1:0]  ai_w;
	logic signed [PW-1:0]  br_w;
	logic signed [PW-1:0]  bi_w;

	assign op_in = op_t'(s_tuser);
	assign a_re  = s_tdata[DW-1:0];
	assign a_im  = s_tdata[2*DW-1:DW];
	assign b_re  = s_tdata[3*DW-1:2*DW];
	assign b_im  = s_tdata[4*DW-1:3*DW];
	assign ar_w  = PW'(a_re);
	assign ai_w  = PW'(a_im);
	assign br_w  = PW'(b_re);
	assign bi_w  = PW'(b_im);

	// ---------------- handshake chain ----------------
	logic  v_s1, v_s2, v_s3;
	logic  rdy_s1, rdy_s2, rdy_s3, rdy_out;
	logic  pipe_in_ready;
	logic  pipe_out_valid;
	iter_t pipe_out;

	assign rdy_out  = !m_tvalid || m_tready;
	assign rdy_s3   = !v_s3 || pipe_in_ready;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign s_tready = rdy_s1;

	// ---------------- stage 1: products ----------------
	// For the modulus opcodes the first two products become the squares of a.
	op_t                  op_s1;
	logic                 zdiv_s1;
	logic signed [DW-1:0] ar_s1, ai_s1, br_s1, bi_s1;
	logic signed [PW-1:0] p0_s1, p1_s1, p2_s1, p3_s1, p4_s1, p5_s1;
	logic                 is_mod_in;

	assign is_mod_in = (op_in == OP_MOD) || (op_in == OP_MOD2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_tvalid) begin
			op_s1   <= op_in;
			zdiv_s1 <= ((op_in == OP_DIV) && (b_re == '0) && (b_im == '0)) ||
			           ((op_in == OP_SDIV) && (b_re == '0));
			ar_s1   <= a_re;
			ai_s1   <= a_im;
			br_s1   <= b_re;
			bi_s1   <= b_im;
			p0_s1   <= ar_w * (is_mod_in ? ar_w : br_w);
			p1_s1   <= ai_w * (is_mod_in ? ai_w : bi_w);
			p2_s1   <= ai_w * br_w;
			p3_s1   <= ar_w * bi_w;
			p4_s1   <= br_w * br_w;
			p5_s1   <= bi_w * bi_w;
		end
	end

	// ---------------- stage 2: sums and direct results ----------------
	op_t                  op_s2;
	logic                 zdiv_s2;
	logic                 negb_s2;
	logic signed [WW-1:0] fast_re_s2, fast_im_s2;
	logic signed [WW-1:0] num_re_s2, num_im_s2;
	logic [PW-1:0]        den_s2;
	logic [PW-1:0]        mag2_s2;

	logic signed [WW-1:0] sr, si, fre, fim, nre, nim, dsum, babs;

	always_comb begin
		sr   = (op_s1 == OP_MUL) ? (WW'(p0_s1) - WW'(p1_s1)) : (WW'(p0_s1) + WW'(p1_s1));
		si   = (op_s1 == OP_MUL) ? (WW'(p2_s1) + WW'(p3_s1)) : (WW'(p2_s1) - WW'(p3_s1));
		dsum = WW'(p4_s1) + WW'(p5_s1);
		babs = br_s1[DW-1] ? -WW'(br_s1) : WW'(br_s1);
		case (op_s1)
			OP_ADD: begin
				fre = WW'(ar_s1) + WW'(br_s1);
				fim = WW'(ai_s1) + WW'(bi_s1);
			end
			OP_SUB: begin
				fre = WW'(ar_s1) - WW'(br_s1);
				fim = WW'(ai_s1) - WW'(bi_s1);
			end
			OP_MUL: begin
				fre = sr >>> FB;
				fim = si >>> FB;
			end
			OP_MOD2: begin
				fre = sr >>> FB;
				fim = '0;
			end
			OP_CONJ: begin
				fre = WW'(ar_s1);
				fim = -WW'(ai_s1);
			end
			default: begin
				fre = '0;
				fim = '0;
			end
		endcase
		if (op_s1 == OP_SDIV) begin
			nre = WW'(ar_s1);
			nim = WW'(ai_s1);
		end else begin
			nre = sr;
			nim = si;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			op_s2      <= op_s1;
			zdiv_s2    <= zdiv_s1;
			negb_s2    <= (op_s1 == OP_SDIV) && br_s1[DW-1];
			fast_re_s2 <= fre;
			fast_im_s2 <= fim;
			num_re_s2  <= nre;
			num_im_s2  <= nim;
			den_s2     <= (op_s1 == OP_SDIV) ? babs[PW-1:0] : dsum[PW-1:0];
			mag2_s2    <= sr[PW-1:0];
		end
	end

	// ---------------- stage 3: divider and root operands ----------------
	iter_t                data_s3;
	iter_t                prep;
	logic signed [WW-1:0] mre, mim;

	always_comb begin
		mre          = num_re_s2[WW-1] ? -num_re_s2 : num_re_s2;
		mim          = num_im_s2[WW-1] ? -num_im_s2 : num_im_s2;
		prep.op      = op_s2;
		prep.zdiv    = zdiv_s2;
		prep.fast_re = fast_re_s2;
		prep.fast_im = fast_im_s2;
		prep.den     = den_s2;
		prep.rem_re  = {mre[NW-FB-1:0], {FB{1'b0}}};
		prep.rem_im  = {mim[NW-FB-1:0], {FB{1'b0}}};
		prep.neg_re  = num_re_s2[WW-1] ^ negb_s2;
		prep.neg_im  = num_im_s2[WW-1] ^ negb_s2;
		prep.q_re    = '0;
		prep.q_im    = '0;
		prep.sq_s    = mag2_s2;
		prep.sq_rem  = '0;
		prep.sq_root = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			data_s3 <= prep;
		end
	end

	cau_iter_pipe u_iter (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.in_ready  (pipe_in_ready),
		.in_data   (data_s3),
		.out_valid (pipe_out_valid),
		.out_ready (rdy_out),
		.out_data  (pipe_out)
	);

	// ---------------- output register: select and clamp ----------------
	logic signed [WW-1:0] cand_re, cand_im;
	logic [DW:0]          cl_re, cl_im;

	always_comb begin
		case (pipe_out.op)
			OP_DIV, OP_SDIV: begin
				if (pipe_out.zdiv) begin
					cand_re = '0;
					cand_im = '0;
				end else begin
					cand_re = quot_fn(pipe_out.q_re, pipe_out.neg_re);
					cand_im = quot_fn(pipe_out.q_im, pipe_out.neg_im);
				end
			end
			OP_MOD: begin
				cand_re = signed'({{(WW-DW){1'b0}}, pipe_out.sq_root});
				cand_im = '0;
			end
			default: begin
				cand_re = pipe_out.fast_re;
				cand_im = pipe_out.fast_im;
			end
		endcase
		cl_re = clamp_fn(cand_re);
		cl_im = clamp_fn(cand_im);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (rdy_out) begin
			m_tvalid <= pipe_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && pipe_out_valid) begin
			m_tdata <= {cl_im[DW-1:0], cl_re[DW-1:0]};
			m_tuser <= {cl_re[DW] | cl_im[DW], pipe_out.zdiv};
		end
	end

endmodule
`default_nettype wire
